// File: design/sbfp_pkg.sv
// Package for the SIXBIT file-spec parser: phase codes, character codes,
// result record and the small SIXBIT helper functions. No dependencies.
package sbfp_pkg;

  localparam int CharW   = 7;
  localparam int WordW   = 36;
  localparam int HalfW   = 18;
  localparam int SixW    = 6;
  localparam int MaxChrs = 6;

  // Delimiter characters
  localparam logic [CharW-1:0] CH_NUL    = 7'h00;
  localparam logic [CharW-1:0] CH_DOT    = 7'h2E;
  localparam logic [CharW-1:0] CH_LBRACK = 7'h5B;
  localparam logic [CharW-1:0] CH_COMMA  = 7'h2C;
  localparam logic [CharW-1:0] CH_RBRACK = 7'h5D;

  typedef enum logic [2:0] {
    PH_NAME = 3'd0,
    PH_EXT  = 3'd1,
    PH_PROJ = 3'd2,
    PH_PROG = 3'd3,
    PH_OK   = 3'd4,
    PH_FAIL = 3'd5
  } phase_t;

  typedef struct packed {
    logic             ok;
    logic [WordW-1:0] name_word;
    logic [HalfW-1:0] ext_half;
    logic [WordW-1:0] ppn_word;
  } result_t;

  // Case fold to SIXBIT: bit 6 set forces bit 5 high, otherwise bit 5 drops.
  function automatic logic [SixW-1:0] fold6(input logic [CharW-1:0] c);
    return {c[6], c[4:0]};
  endfunction

  function automatic logic is_delim(input logic [CharW-1:0] c);
    return (c == CH_NUL) || (c == CH_DOT) || (c == CH_LBRACK) ||
           (c == CH_COMMA) || (c == CH_RBRACK);
  endfunction

  // Right-justify three SIXBIT characters within an 18-bit half.
  function automatic logic [HalfW-1:0] rjust3(input logic [HalfW-1:0] v);
    logic [HalfW-1:0] r;
    if (v[5:0] != '0) begin
      r = v;
    end else if (v[11:6] != '0) begin
      r = {6'b0, v[17:6]};
    end else begin
      r = {12'b0, v[17:12]};
    end
    return r;
  endfunction

endpackage

// File: design/sbfp_in_stage.sv
// Input register for the SIXBIT parser: holds one character request.
// Depends on sbfp_pkg.
module sbfp_in_stage (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [sbfp_pkg::CharW-1:0] in_char,
  input  logic                      take,
  output logic                      held_valid,
  output logic [sbfp_pkg::CharW-1:0] held_char
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_char <= in_char;
    end
  end

endmodule

// File: design/sbfp_parse.sv
// Parser state and one-character step: packs fields into SIXBIT words and
// tracks the delimiter phase. Depends on sbfp_pkg.
module sbfp_parse (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [sbfp_pkg::CharW-1:0] chr,
  output logic                       emit,
  output sbfp_pkg::result_t          res
);

  sbfp_pkg::phase_t             phase, phase_next;
  logic [2:0]                   char_count, char_count_next;
  logic [sbfp_pkg::WordW-1:0]   field_acc, field_acc_next;
  logic [sbfp_pkg::WordW-1:0]   name_reg, name_reg_next;
  logic [sbfp_pkg::HalfW-1:0]   ext_reg, ext_reg_next;
  logic [sbfp_pkg::WordW-1:0]   ppn_reg, ppn_reg_next;

  logic                         good;
  logic                         done;
  logic [sbfp_pkg::HalfW-1:0]   rj;
  logic [sbfp_pkg::WordW-1:0]   slot;

  assign done = (phase != sbfp_pkg::PH_NAME) && (phase != sbfp_pkg::PH_EXT) &&
                (phase != sbfp_pkg::PH_PROJ) && (phase != sbfp_pkg::PH_PROG);
  assign rj   = sbfp_pkg::rjust3(field_acc[sbfp_pkg::WordW-1:sbfp_pkg::HalfW]);

  // Place the folded character at its slot, first character at the top.
  always_comb begin
    slot = '0;
    case (char_count)
      3'd0:    slot[35:30] = sbfp_pkg::fold6(chr);
      3'd1:    slot[29:24] = sbfp_pkg::fold6(chr);
      3'd2:    slot[23:18] = sbfp_pkg::fold6(chr);
      3'd3:    slot[17:12] = sbfp_pkg::fold6(chr);
      3'd4:    slot[11:6]  = sbfp_pkg::fold6(chr);
      3'd5:    slot[5:0]   = sbfp_pkg::fold6(chr);
      default: slot = '0;
    endcase
  end

  always_comb begin
    phase_next      = phase;
    char_count_next = char_count;
    field_acc_next  = field_acc;
    name_reg_next   = name_reg;
    ext_reg_next    = ext_reg;
    ppn_reg_next    = ppn_reg;
    emit            = 1'b0;
    good            = 1'b0;

    if (done) begin
      // Skipping to the terminating zero byte
      if (chr == sbfp_pkg::CH_NUL) begin
        emit = 1'b1;
        good = (phase == sbfp_pkg::PH_OK);
      end
    end else if (!sbfp_pkg::is_delim(chr)) begin
      if (char_count < 3'(sbfp_pkg::MaxChrs)) begin
        field_acc_next  = field_acc | slot;
        char_count_next = char_count + 3'd1;
      end
    end else begin
      field_acc_next  = '0;
      char_count_next = '0;
      unique case (phase)
        sbfp_pkg::PH_NAME: begin
          name_reg_next = field_acc;
          if (chr == sbfp_pkg::CH_NUL) begin
            emit = 1'b1;
            good = 1'b1;
          end else if (chr == sbfp_pkg::CH_DOT) begin
            phase_next = sbfp_pkg::PH_EXT;
          end else if (chr == sbfp_pkg::CH_LBRACK) begin
            phase_next = sbfp_pkg::PH_PROJ;
          end else begin
            phase_next = sbfp_pkg::PH_FAIL;
          end
        end
        sbfp_pkg::PH_EXT: begin
          ext_reg_next = field_acc[sbfp_pkg::WordW-1:sbfp_pkg::HalfW];
          if (chr == sbfp_pkg::CH_NUL) begin
            emit = 1'b1;
            good = 1'b1;
          end else if (chr == sbfp_pkg::CH_LBRACK) begin
            phase_next = sbfp_pkg::PH_PROJ;
          end else begin
            phase_next = sbfp_pkg::PH_FAIL;
          end
        end
        sbfp_pkg::PH_PROJ: begin
          ppn_reg_next = {rj, {sbfp_pkg::HalfW{1'b0}}};
          if (chr == sbfp_pkg::CH_COMMA) begin
            phase_next = sbfp_pkg::PH_PROG;
          end else if (chr == sbfp_pkg::CH_NUL) begin
            emit = 1'b1;
          end else begin
            phase_next = sbfp_pkg::PH_FAIL;
          end
        end
        default: begin
          // Programmer: any delimiter closes the spec successfully
          ppn_reg_next = {ppn_reg[sbfp_pkg::WordW-1:sbfp_pkg::HalfW],
                          ppn_reg[sbfp_pkg::HalfW-1:0] | rj};
          if (chr == sbfp_pkg::CH_NUL) begin
            emit = 1'b1;
            good = 1'b1;
          end else begin
            phase_next = sbfp_pkg::PH_OK;
          end
        end
      endcase
    end

    res.ok        = good;
    res.name_word = good ? name_reg_next : '0;
    res.ext_half  = good ? ext_reg_next  : '0;
    res.ppn_word  = good ? ppn_reg_next  : '0;

    // A result restarts the parser for the next name
    if (emit) begin
      phase_next      = sbfp_pkg::PH_NAME;
      char_count_next = '0;
      field_acc_next  = '0;
      name_reg_next   = '0;
      ext_reg_next    = '0;
      ppn_reg_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= sbfp_pkg::PH_NAME;
      char_count <= '0;
      field_acc  <= '0;
      name_reg   <= '0;
      ext_reg    <= '0;
      ppn_reg    <= '0;
    end else if (step) begin
      phase      <= phase_next;
      char_count <= char_count_next;
      field_acc  <= field_acc_next;
      name_reg   <= name_reg_next;
      ext_reg    <= ext_reg_next;
      ppn_reg    <= ppn_reg_next;
    end
  end

endmodule

// File: design/sbfp_out_stage.sv
// Result register for the SIXBIT parser: holds one result until taken.
// Depends on sbfp_pkg.
module sbfp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  sbfp_pkg::result_t load_res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output sbfp_pkg::result_t out_res
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= load_res;
    end
  end

endmodule

// File: design/sixbit_filespec_parser_core.sv
// Top level of the SIXBIT file-spec parser: input register, parse step and
// result register. Depends on sbfp_pkg, sbfp_in_stage, sbfp_parse, sbfp_out_stage.
//
//   channel | dir | carries                      | request taken when
//   --------+-----+------------------------------+-----------------------
//   s_*     | in  | one character of a file spec | s_tvalid && s_tready
//   m_*     | out | parse result at the zero byte| m_tvalid && m_tready
//
// Flow: one character per clock while the result register is free; a character
//   waits in the input register and is parsed as it leaves, so a result is
//   loaded into the result register as its zero byte leaves the input register.
// Reset: rst (synchronous) returns the parser to the name phase and empties
//   both registers.
// Stalls: a character leaves the input register only while the result
//   register is empty or being drained, so with a result waiting and m_tready
//   low, s_tready drops as soon as the input register holds a character.
module sixbit_filespec_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [6:0] char_in, [7] pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata    // [0] ok, [36:1] name_word, [54:37] ext_half,
                                 // [90:55] ppn_word, [95:91] zero
);

  logic                       held_valid;
  logic [sbfp_pkg::CharW-1:0] held_char;
  logic                       step;
  logic                       emit;
  logic                       free;
  sbfp_pkg::result_t          step_res;
  sbfp_pkg::result_t          out_res;

  // Parse a held character whenever the result slot can absorb an output
  assign step = held_valid && free;

  sbfp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_char    (s_tdata[sbfp_pkg::CharW-1:0]),
    .take       (step),
    .held_valid (held_valid),
    .held_char  (held_char)
  );

  sbfp_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .chr  (held_char),
    .emit (emit),
    .res  (step_res)
  );

  sbfp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && emit),
    .load_res  (step_res),
    .free      (free),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  // Pack result fields, first field in the low bits
  assign m_tdata = {5'b0, out_res.ppn_word, out_res.ext_half,
                    out_res.name_word, out_res.ok};

endmodule
